@@ src/greedy_box_nms_macros.svh @@
// Assertion macros for the greedy box NMS block.
// Uses the clk and arst_n names of the module that includes it.
`ifndef GREEDY_BOX_NMS_MACROS_SVH
`define GREEDY_BOX_NMS_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge out of reset
`define GBNMS_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("greedy_box_nms: check failed");
// Property that must hold in the cycle after a trigger
`define GBNMS_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("greedy_box_nms: check failed");
`else
`define GBNMS_ALWAYS(lbl, cond)
`define GBNMS_NEXT(lbl, pre, post)
`endif
`endif

@@ src/gbnms_pkg.sv @@
// Shared types and constants for the greedy box NMS block.
// No dependencies; used by gbnms_iou and greedy_box_nms.
package gbnms_pkg;

	localparam int MAX_KEPT   = 64;
	localparam int COORD_BITS = 16;
	localparam int IDX_W      = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W      = $clog2(MAX_KEPT + 1);

	localparam int LIM_W      = 16;
	localparam int IOU_FRAC   = 16;
	localparam int AREA_W     = 2 * COORD_BITS;
	localparam int UNI_W      = AREA_W + 1;
	localparam int LHS_W      = AREA_W + IOU_FRAC;
	localparam int PROD_W     = UNI_W + LIM_W;

	localparam int LABEL_W    = 10;
	localparam int TAG_W      = 16;
	localparam int FIELD_W    = 16;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 32;

	localparam logic [LIM_W-1:0] IOU_LIMIT_RST = 16'h8000;

	typedef struct packed {
		logic [COORD_BITS-1:0] bottom;
		logic [COORD_BITS-1:0] right;
		logic [COORD_BITS-1:0] top;
		logic [COORD_BITS-1:0] left;
	} box_t;

	typedef struct packed {
		logic valid;
		logic hit;
	} iou_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

@@ src/gbnms_iou.sv @@
// Pipelined IoU threshold test of one kept box against the current box.
// Depends on gbnms_pkg; five register stages, one pair accepted per cycle.
module gbnms_iou (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  gbnms_pkg::box_t              kept_box,
	input  gbnms_pkg::box_t              cur_box,
	input  logic [gbnms_pkg::LIM_W-1:0]  iou_limit,
	output gbnms_pkg::iou_res_t          res
);

	localparam int CW = gbnms_pkg::COORD_BITS;
	localparam int AW = gbnms_pkg::AREA_W;
	localparam int UW = gbnms_pkg::UNI_W;
	localparam int LW = gbnms_pkg::LHS_W;
	localparam int PW = gbnms_pkg::PROD_W;

	function automatic logic [CW-1:0] ext_f(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
		return (hi > lo) ? (hi - lo) : '0;
	endfunction

	logic [CW-1:0] x0, y0, x1, y1;

	logic          v_s1, v_s2, v_s3, v_s4;
	logic [CW-1:0] ax_s1, ay_s1, bx_s1, by_s1, ox_s1, oy_s1;
	logic [AW-1:0] area_a_s2, area_b_s2, ov_s2;
	logic [UW-1:0] uni_s3;
	logic [AW-1:0] ov_s3;
	logic [PW-1:0] rhs_s4;
	logic [LW-1:0] lhs_s4;
	logic          nz_s4;
	logic          hit_q, valid_q;

	// Intersection corners
	always_comb begin
		x0 = (kept_box.left > cur_box.left) ? kept_box.left : cur_box.left;
		y0 = (kept_box.top > cur_box.top) ? kept_box.top : cur_box.top;
		x1 = (kept_box.right < cur_box.right) ? kept_box.right : cur_box.right;
		y1 = (kept_box.bottom < cur_box.bottom) ? kept_box.bottom : cur_box.bottom;
	end

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			valid_q <= v_s4;
		end
	end

	// Extents, areas, union, scaled products, final compare
	always_ff @(posedge clk) begin
		ax_s1     <= ext_f(kept_box.left, kept_box.right);
		ay_s1     <= ext_f(kept_box.top, kept_box.bottom);
		bx_s1     <= ext_f(cur_box.left, cur_box.right);
		by_s1     <= ext_f(cur_box.top, cur_box.bottom);
		ox_s1     <= ext_f(x0, x1);
		oy_s1     <= ext_f(y0, y1);

		area_a_s2 <= AW'(ax_s1) * AW'(ay_s1);
		area_b_s2 <= AW'(bx_s1) * AW'(by_s1);
		ov_s2     <= AW'(ox_s1) * AW'(oy_s1);

		uni_s3    <= UW'(area_a_s2) + UW'(area_b_s2) - UW'(ov_s2);
		ov_s3     <= ov_s2;

		rhs_s4    <= PW'(uni_s3) * PW'(iou_limit);
		lhs_s4    <= {ov_s3, {gbnms_pkg::IOU_FRAC{1'b0}}};
		nz_s4     <= (uni_s3 != '0) && (ov_s3 != '0);

		hit_q     <= nz_s4 && (PW'(lhs_s4) > rhs_s4);
	end

	assign res.valid = valid_q;
	assign res.hit   = hit_q;

endmodule

@@ src/greedy_box_nms.sv @@
// Greedy NMS top level: each input transaction is compared against every kept box before its
// result is registered. One IoU test is issued per cycle through a five-stage compare unit
// during the store scan. A new item is taken only in the idle state, after the last is committed.
// A finished result waits in an output register while the next item is taken.
// arst_n clears the kept count, the FSM and the output valid; iou_limit resets to 32768.
// The kept-box memory has no reset: only entries below kept_count are read.
`include "greedy_box_nms_macros.svh"

module greedy_box_nms (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// left[15:0] top[31:16] right[47:32] bottom[63:48] class_label[73:64] box_tag[89:74]
	input  logic [gbnms_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic                                  s_tlast,
	// keep[0] store_overflow[1] out_label[11:2] out_tag[27:12]
	output logic [gbnms_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic                                  m_tlast,
	input  logic                                  cfg_we,
	input  logic [gbnms_pkg::LIM_W-1:0]           cfg_wdata
);

	localparam int CW  = gbnms_pkg::COORD_BITS;
	localparam int FW  = gbnms_pkg::FIELD_W;
	localparam int NW  = gbnms_pkg::CNT_W;
	localparam int XW  = gbnms_pkg::IDX_W;
	localparam int LBW = gbnms_pkg::LABEL_W;
	localparam int TGW = gbnms_pkg::TAG_W;

	gbnms_pkg::state_t   state_q, state_nx;
	gbnms_pkg::box_t     mem [gbnms_pkg::MAX_KEPT];
	gbnms_pkg::box_t     rd_box_q, cur_box_q;
	gbnms_pkg::iou_res_t iou_res;

	logic [gbnms_pkg::LIM_W-1:0] limit_q;
	logic [NW-1:0]  cnt_q, issue_q, ret_q;
	logic           rd_v_q;
	logic           hit_acc_q;
	logic [LBW-1:0] cur_label_q;
	logic [TGW-1:0] cur_tag_q;
	logic           cur_last_q;
	logic           accept, rd_en, commit, keep, full, wr_en;

	logic           m_valid_q, m_keep_q, m_ovf_q, m_last_q;
	logic [LBW-1:0] m_label_q;
	logic [TGW-1:0] m_tag_q;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			gbnms_pkg::ST_IDLE: if (s_tvalid) state_nx = gbnms_pkg::ST_SCAN;
			gbnms_pkg::ST_SCAN: if (ret_q == cnt_q) state_nx = gbnms_pkg::ST_DONE;
			gbnms_pkg::ST_DONE: if (!m_valid_q || m_tready) state_nx = gbnms_pkg::ST_IDLE;
			default:            state_nx = gbnms_pkg::ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		commit   = 1'b0;
		case (state_q)
			gbnms_pkg::ST_IDLE: s_tready = 1'b1;
			gbnms_pkg::ST_SCAN: rd_en    = (issue_q < cnt_q);
			gbnms_pkg::ST_DONE: commit   = !m_valid_q || m_tready;
			default:            s_tready = 1'b0;
		endcase
	end

	assign accept = s_tvalid && s_tready;
	assign keep   = !hit_acc_q;
	assign full   = (cnt_q == NW'(gbnms_pkg::MAX_KEPT));
	assign wr_en  = commit && keep && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gbnms_pkg::ST_IDLE;
		else         state_q <= state_nx;
	end

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     limit_q <= gbnms_pkg::IOU_LIMIT_RST;
		else if (cfg_we) limit_q <= cfg_wdata;
	end

	// Capture the current box
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_box_q.left   <= CW'(s_tdata[FW-1:0]);
			cur_box_q.top    <= CW'(s_tdata[2*FW-1:FW]);
			cur_box_q.right  <= CW'(s_tdata[3*FW-1:2*FW]);
			cur_box_q.bottom <= CW'(s_tdata[4*FW-1:3*FW]);
			cur_label_q      <= s_tdata[4*FW+LBW-1:4*FW];
			cur_tag_q        <= s_tdata[4*FW+LBW+TGW-1:4*FW+LBW];
			cur_last_q       <= s_tlast;
		end
	end

	// Scan counters, hit accumulation and kept count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q   <= '0;
			ret_q     <= '0;
			hit_acc_q <= 1'b0;
			cnt_q     <= '0;
			rd_v_q    <= 1'b0;
		end else begin
			rd_v_q <= rd_en;
			if (accept) begin
				issue_q   <= '0;
				ret_q     <= '0;
				hit_acc_q <= 1'b0;
			end else begin
				if (rd_en) issue_q <= issue_q + NW'(1);
				if (iou_res.valid) begin
					ret_q     <= ret_q + NW'(1);
					hit_acc_q <= hit_acc_q | iou_res.hit;
				end
			end
			if (commit) begin
				if (cur_last_q) cnt_q <= '0;
				else if (wr_en) cnt_q <= cnt_q + NW'(1);
			end
		end
	end

	// Kept-box store: write on commit of a kept box while not full, registered read during scan
	always_ff @(posedge clk) begin
		if (wr_en) mem[cnt_q[XW-1:0]] <= cur_box_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_box_q <= mem[issue_q[XW-1:0]];
	end

	gbnms_iou u_iou (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rd_v_q),
		.kept_box  (rd_box_q),
		.cur_box   (cur_box_q),
		.iou_limit (limit_q),
		.res       (iou_res)
	);

	// Output register: load on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       m_valid_q <= 1'b0;
		else if (commit)   m_valid_q <= 1'b1;
		else if (m_tready) m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_keep_q  <= keep;
			m_ovf_q   <= keep && full;
			m_label_q <= cur_label_q;
			m_tag_q   <= cur_tag_q;
			m_last_q  <= cur_last_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {{(gbnms_pkg::OUT_DATA_W - 2 - LBW - TGW){1'b0}},
		m_tag_q, m_label_q, m_ovf_q, m_keep_q};

	`GBNMS_ALWAYS(a_cnt_max, cnt_q <= NW'(gbnms_pkg::MAX_KEPT))
	`GBNMS_ALWAYS(a_issue_le_cnt, state_q != gbnms_pkg::ST_SCAN || issue_q <= cnt_q)
	`GBNMS_ALWAYS(a_ret_le_issue, ret_q <= issue_q)
	`GBNMS_NEXT(a_last_clears, commit && cur_last_q, cnt_q == '0)
	`GBNMS_NEXT(a_commit_loads, commit, m_valid_q)

endmodule
